// ----- design/tti_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Thermistor table interpolator package
// Shared widths, codes, state encoding and the calibration ROM.
// ----------------------------------------------------------------------------
package tti_pkg;

   localparam int ADC_W    = 12;
   localparam int TEMP_W   = 15;
   localparam int FLAG_W   = 2;
   localparam int ROM_LEN  = 90;
   localparam int IDX_W    = $clog2(ROM_LEN + 1);

   localparam int TEMP_LOW_C  = -30;
   localparam int TEMP_HIGH_C = 60;

   localparam int TABLE_ENTRIES_DEF = 90;
   localparam int FRACTION_BITS_DEF = 8;

   localparam logic [FLAG_W-1:0] RANGE_INTERP = 2'd0;
   localparam logic [FLAG_W-1:0] RANGE_LOW    = 2'd1;
   localparam logic [FLAG_W-1:0] RANGE_HIGH   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIVIDE,
      ST_DONE
   } tti_state_type;

   typedef struct packed {
      logic             start;
      logic [ADC_W-1:0] remainder;
      logic [ADC_W-1:0] divisor;
   } tti_div_cmd_type;

   localparam logic [ADC_W-1:0] CAL_ROM [ROM_LEN] = '{
      12'd332,  12'd349,  12'd365,  12'd383,  12'd401,
      12'd419,  12'd439,  12'd458,  12'd479,  12'd522,
      12'd545,  12'd568,  12'd592,  12'd617,  12'd642,
      12'd668,  12'd695,  12'd722,  12'd750,  12'd779,
      12'd808,  12'd838,  12'd869,  12'd900,  12'd931,
      12'd964,  12'd996,  12'd1030, 12'd1064, 12'd1098,
      12'd1133, 12'd1168, 12'd1204, 12'd1240, 12'd1276,
      12'd1313, 12'd1351, 12'd1388, 12'd1426, 12'd1464,
      12'd1502, 12'd1541, 12'd1580, 12'd1619, 12'd1658,
      12'd1697, 12'd1736, 12'd1775, 12'd1814, 12'd1854,
      12'd1893, 12'd1932, 12'd1971, 12'd2009, 12'd2048,
      12'd2086, 12'd2125, 12'd2163, 12'd2200, 12'd2238,
      12'd2275, 12'd2311, 12'd2347, 12'd2383, 12'd2419,
      12'd2454, 12'd2489, 12'd2523, 12'd2557, 12'd2590,
      12'd2623, 12'd2655, 12'd2687, 12'd2718, 12'd2748,
      12'd2779, 12'd2808, 12'd2837, 12'd2866, 12'd2894,
      12'd2922, 12'd2949, 12'd2975, 12'd3001, 12'd3027,
      12'd3052, 12'd3076, 12'd3100, 12'd3123, 12'd3146
   };

   // Entries past the end of the table read as zero.
   function automatic logic [ADC_W-1:0] cal_rom(input logic [IDX_W-1:0] idx);
      logic [ADC_W-1:0] val;
      val = '0;
      for (int k = 0; k < ROM_LEN; k++) begin
         if (idx == IDX_W'(k)) begin
            val = CAL_ROM[k];
         end
      end
      return val;
   endfunction

endpackage
`default_nettype wire

// ----- design/tti_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Carries one ADC conversion item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tti_req_if;
   import tti_pkg::*;

   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] adc_code;

   modport source (output valid, output adc_code, input ready);
   modport sink   (input valid, input adc_code, output ready);
endinterface
`default_nettype wire

// ----- design/tti_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Carries one temperature item and its range flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tti_rsp_if;
   import tti_pkg::*;

   logic              valid;
   logic              ready;
   logic [TEMP_W-1:0] temperature_q8;
   logic [FLAG_W-1:0] range_flag;

   modport source (output valid, output temperature_q8, output range_flag, input ready);
   modport sink   (input valid, input temperature_q8, input range_flag, output ready);
endinterface
`default_nettype wire

// ----- design/tti_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Serial fraction divider
// Restoring divider that produces one quotient bit of (rem << FB) / div per
// cycle. The starting remainder may equal the divisor, so the first step
// compares without shifting and gives the integer bit of the quotient.
// ----------------------------------------------------------------------------
module tti_divider #(
   parameter int FRACTION_BITS = tti_pkg::FRACTION_BITS_DEF,
   parameter int QUO_W         = FRACTION_BITS + 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tti_pkg::tti_div_cmd_type cmd,
   output logic                          done,
   output logic [QUO_W-1:0]              quotient
);
   import tti_pkg::*;

   localparam int CNT_W = $clog2(FRACTION_BITS + 2);

   logic             busy_ff, busy_in;
   logic             first_ff, first_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ADC_W-1:0] rem_ff, rem_in;
   logic [ADC_W-1:0] div_ff, div_in;
   logic [QUO_W-1:0] quot_ff, quot_in;
   logic [ADC_W:0]   rem_dbl;
   logic [ADC_W:0]   rem_sub;
   logic             bit_set;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      first_ff <= first_in;
      count_ff <= count_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      quot_ff  <= quot_in;
   end

   always_comb begin
      // The integer step uses the remainder as loaded; later steps double it.
      rem_dbl  = first_ff ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      rem_sub  = rem_dbl - {1'b0, div_ff};
      bit_set  = (rem_dbl >= {1'b0, div_ff});
      busy_in  = busy_ff;
      first_in = first_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quot_in  = quot_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         count_in = CNT_W'(FRACTION_BITS + 1);
         rem_in   = cmd.remainder;
         div_in   = cmd.divisor;
         quot_in  = '0;
      end else if (busy_ff) begin
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            first_in = 1'b0;
            count_in = count_ff - CNT_W'(1);
            // The remainder stays below the divisor, so it fits back in ADC_W bits.
            rem_in   = bit_set ? rem_sub[ADC_W-1:0] : rem_dbl[ADC_W-1:0];
            quot_in  = QUO_W'({quot_ff, bit_set});
         end
      end
   end

   assign done     = busy_ff && (count_ff == '0);
   assign quotient = quot_ff;

endmodule
`default_nettype wire

// ----- design/thermistor_table_interpolator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Thermistor table interpolator
// Binary search over the calibration ROM, then a serial divider for the
// fraction between the two bracketing entries.
// ----------------------------------------------------------------------------
// Steps: a binary search and a decision, then the serial divider when
// interpolating, then a load of the response register. One item is in
// work at a time; the next is accepted in the cycle after the result is
// loaded. A waiting response stalls the load.
// Reset is synchronous and clears control.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator_unit #(
   parameter int TABLE_ENTRIES = tti_pkg::TABLE_ENTRIES_DEF,
   parameter int FRACTION_BITS = tti_pkg::FRACTION_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   tti_req_if.sink   req_ch,
   tti_rsp_if.source rsp_ch
);
   import tti_pkg::*;

   localparam int LIMIT = (TABLE_ENTRIES < ROM_LEN) ? TABLE_ENTRIES : ROM_LEN;
   // One extra quotient bit holds the full step when the code sits on an entry.
   localparam int QUO_W = FRACTION_BITS + 1;
   localparam int BASE_W = IDX_W + 1 + FRACTION_BITS;
   localparam int SUM_W = (BASE_W > TEMP_W) ? BASE_W : TEMP_W;

   tti_state_type     state_ff, state_in;
   logic [ADC_W-1:0]  code_ff, code_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [FLAG_W-1:0] flag_ff, flag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic [FLAG_W-1:0] rsp_flag_ff, rsp_flag_in;

   logic [IDX_W:0]       mid_sum;
   logic [IDX_W-1:0]     mid;
   logic [ADC_W-1:0]     mid_val;
   logic [ADC_W-1:0]     low_val;
   logic [ADC_W-1:0]     high_val;
   logic signed [IDX_W:0] base;
   logic [SUM_W-1:0]     interp_sum;
   logic [SUM_W-1:0]     clamp_low;
   logic [SUM_W-1:0]     clamp_high;
   logic                 slot_free;

   tti_div_cmd_type  div_cmd;
   logic             div_done;
   logic [QUO_W-1:0] div_quot;

   tti_divider #(
      .FRACTION_BITS (FRACTION_BITS),
      .QUO_W         (QUO_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff     <= code_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      flag_ff     <= flag_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   always_comb begin
      mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid      = mid_sum[IDX_W:1];
      mid_val  = cal_rom(mid);
      low_val  = cal_rom(lo_ff - IDX_W'(1));
      high_val = cal_rom(lo_ff);

      base       = $signed({1'b0, lo_ff}) + (IDX_W+1)'(TEMP_LOW_C);
      interp_sum = (SUM_W'(base) << FRACTION_BITS) + SUM_W'(div_quot);
      clamp_low  = SUM_W'(TEMP_LOW_C) << FRACTION_BITS;
      clamp_high = SUM_W'(TEMP_HIGH_C) << FRACTION_BITS;
   end

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_temp_in  = rsp_temp_ff;
      rsp_flag_in  = rsp_flag_ff;
      div_cmd      = '{start: 1'b0, remainder: code_ff - low_val, divisor: high_val - low_val};
      req_ch.ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               code_in  = req_ch.adc_code;
               lo_in    = '0;
               hi_in    = IDX_W'(LIMIT);
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (lo_ff != hi_ff) begin
               // Lower bound search: first entry at least the code.
               if (mid_val < code_ff) begin
                  lo_in = mid + IDX_W'(1);
               end else begin
                  hi_in = mid;
               end
            end else if (lo_ff == IDX_W'(LIMIT)) begin
               flag_in  = RANGE_HIGH;
               state_in = ST_DONE;
            end else if (lo_ff == '0) begin
               flag_in  = RANGE_LOW;
               state_in = ST_DONE;
            end else begin
               flag_in       = RANGE_INTERP;
               div_cmd.start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = flag_ff;
               case (flag_ff)
                  RANGE_HIGH: rsp_temp_in = clamp_high[TEMP_W-1:0];
                  RANGE_LOW:  rsp_temp_in = clamp_low[TEMP_W-1:0];
                  default:    rsp_temp_in = interp_sum[TEMP_W-1:0];
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.temperature_q8 = rsp_temp_ff;
   assign rsp_ch.range_flag     = rsp_flag_ff;

endmodule
`default_nettype wire

// ----- dv/thermistor_table_interpolator_unit_test.sv -----
// ----------------------------------------------------------------------------
// Thermistor table interpolator testbench
// Sends ADC codes through the request channel and checks every temperature
// item against an in-bench table search and interpolation, in order. A short
// directed table covers the clamps, the table ends and exact entries. Random
// codes follow under three idle mixes, with one long response stall and
// drains between phases.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tti_pkg::*;

   localparam int FRACTION_BITS = FRACTION_BITS_DEF;
   localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
   localparam int SEARCH_LEN    = (TABLE_ENTRIES < ROM_LEN) ? TABLE_ENTRIES : ROM_LEN;
   localparam int ONE_Q         = 1 << FRACTION_BITS;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      logic [TEMP_W-1:0] temp_q8;
      logic [FLAG_W-1:0] flag;
   } reading_type;

   typedef struct packed {
      logic [ADC_W-1:0] code;
      logic             typed;
      reading_type      want;
   } probe_type;

   localparam int PROBE_COUNT = 21;

   // Rows with typed set carry a result that is read straight off the table.
   localparam probe_type PROBES [PROBE_COUNT] = '{
      '{12'd0,    1'b1, '{TEMP_W'(-7680), RANGE_LOW}},
      '{12'd1,    1'b0, '{'0, RANGE_INTERP}},
      '{12'd331,  1'b0, '{'0, RANGE_INTERP}},
      '{12'd332,  1'b1, '{TEMP_W'(-7680), RANGE_LOW}},
      '{12'd333,  1'b0, '{'0, RANGE_INTERP}},
      '{12'd340,  1'b0, '{'0, RANGE_INTERP}},
      '{12'd349,  1'b1, '{TEMP_W'(-7168), RANGE_INTERP}},
      '{12'd350,  1'b0, '{'0, RANGE_INTERP}},
      '{12'd480,  1'b0, '{'0, RANGE_INTERP}},
      '{12'd500,  1'b0, '{'0, RANGE_INTERP}},
      '{12'd1464, 1'b0, '{'0, RANGE_INTERP}},
      '{12'd2047, 1'b0, '{'0, RANGE_INTERP}},
      '{12'd2048, 1'b0, '{'0, RANGE_INTERP}},
      '{12'd2730, 1'b0, '{'0, RANGE_INTERP}},
      '{12'd1365, 1'b0, '{'0, RANGE_INTERP}},
      '{12'd3100, 1'b0, '{'0, RANGE_INTERP}},
      '{12'd3145, 1'b0, '{'0, RANGE_INTERP}},
      '{12'd3146, 1'b1, '{TEMP_W'(15360), RANGE_INTERP}},
      '{12'd3147, 1'b1, '{TEMP_W'(15360), RANGE_HIGH}},
      '{12'd4000, 1'b0, '{'0, RANGE_INTERP}},
      '{12'd4095, 1'b1, '{TEMP_W'(15360), RANGE_HIGH}}
   };

   logic clock;
   logic reset;

   tti_req_if req_ch ();
   tti_rsp_if rsp_ch ();

   thermistor_table_interpolator_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   reading_type expected_readings [$];
   logic        offered_typed;
   reading_type offered_reading;
   int          codes_sent;
   int          readings_seen;
   int          mismatches;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          ready_hold;
   int          quiet_cycles;

   // First entry at or above the code, then linear interpolation below it.
   function automatic reading_type convert_code(input logic [ADC_W-1:0] code);
      int unsigned c;
      int unsigned idx;
      int unsigned lo;
      int unsigned hi;
      int unsigned frac;
      reading_type r;
      c   = code;
      idx = 0;
      while (idx < SEARCH_LEN && CAL_ROM[idx] < c) begin
         idx++;
      end
      if (idx >= SEARCH_LEN) begin
         r.temp_q8 = TEMP_W'(TEMP_HIGH_C * ONE_Q);
         r.flag    = RANGE_HIGH;
      end else if (idx == 0) begin
         r.temp_q8 = TEMP_W'(TEMP_LOW_C * ONE_Q);
         r.flag    = RANGE_LOW;
      end else begin
         lo   = CAL_ROM[idx-1];
         hi   = CAL_ROM[idx];
         frac = 0;
         if (hi > lo) begin
            frac = ((c - lo) << FRACTION_BITS) / (hi - lo);
         end
         r.temp_q8 = TEMP_W'((int'(idx) + TEMP_LOW_C) * ONE_Q + int'(frac));
         r.flag    = RANGE_INTERP;
      end
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: random idling, or a counted hold when one is requested.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (ready_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            ready_hold--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      reading_type got;
      reading_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            expected_readings.push_back(offered_typed ? offered_reading
                                                      : convert_code(req_ch.adc_code));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            readings_seen++;
            got = '{rsp_ch.temperature_q8, rsp_ch.range_flag};
            if (expected_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("unexpected item: temp %0d flag %0d",
                           $signed(got.temp_q8), got.flag);
               end
            end else begin
               want = expected_readings.pop_front();
               if (got.temp_q8 !== want.temp_q8 || got.flag !== want.flag) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("mismatch: temp exp %0d got %0d, flag exp %0d got %0d",
                              $signed(want.temp_q8), $signed(got.temp_q8),
                              want.flag, got.flag);
                  end
               end
            end
         end
      end
   end

   // Ends the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("thermistor_table_interpolator_unit_test: errors");
            $finish;
         end
      end
   end

   // Valid stays high between back-to-back items; it drops only on an idle cycle.
   task automatic send_code(input logic [ADC_W-1:0] code, input logic typed,
                            input reading_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.adc_code <= code;
      offered_typed   <= typed;
      offered_reading <= want;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      codes_sent++;
   endtask

   task automatic wait_for_readings();
      req_ch.valid <= 1'b0;
      while (readings_seen != codes_sent) begin
         @(posedge clock);
      end
   endtask

   // Mostly codes inside the table, some at or next to the entries, some anywhere.
   task automatic run_random(input int count);
      int sel;
      int v;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 65) begin
            v = $urandom_range(CAL_ROM[0] + 1, CAL_ROM[ROM_LEN-1]);
         end else if (sel < 80) begin
            v = int'(CAL_ROM[$urandom_range(0, ROM_LEN - 1)]) + $urandom_range(0, 2) - 1;
         end else begin
            v = $urandom_range(0, 4095);
         end
         send_code(ADC_W'(v), 1'b0, '0);
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.adc_code <= '0;
      offered_typed   <= 1'b0;
      offered_reading <= '0;
      codes_sent      = 0;
      readings_seen   = 0;
      mismatches      = 0;
      ready_hold      = 0;
      quiet_cycles    = 0;
      send_idle_pct   = 16;
      recv_idle_pct   = 82;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PROBE_COUNT; p++) begin
         send_code(PROBES[p].code, PROBES[p].typed, PROBES[p].want);
      end

      run_random(120);
      // Hold the response side while codes keep coming so the block backs up.
      ready_hold = 400;
      run_random(12);
      run_random(138);
      wait_for_readings();

      send_idle_pct = 82;
      recv_idle_pct = 16;
      run_random(270);
      wait_for_readings();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(260);
      wait_for_readings();
      repeat (30) @(posedge clock);

      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("thermistor_table_interpolator_unit_test: clean");
      end else begin
         $display("thermistor_table_interpolator_unit_test: errors");
      end
      $finish;
   end

endmodule
